/* rtl/core/gsrr_pkg.sv */
package gsrr_pkg;

  // input item codes
  localparam logic [1:0] MODE_SYM   = 2'd0;
  localparam logic [1:0] MODE_LEN   = 2'd1;
  localparam logic [1:0] MODE_SHIFT = 2'd2;
  localparam logic [1:0] MODE_END   = 2'd3;

  // result action codes
  localparam logic [2:0] ACT_SHIFT  = 3'd0;
  localparam logic [2:0] ACT_REDUCE = 3'd1;
  localparam logic [2:0] ACT_ACCEPT = 3'd2;
  localparam logic [2:0] ACT_REJECT = 3'd3;
  localparam logic [2:0] ACT_OVFL   = 3'd4;
  localparam logic [2:0] ACT_LIMIT  = 3'd5;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] rule;
    logic [6:0] depth;
    logic [7:0] top;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RULE  = 5'b00010,
    S_RD    = 5'b00100,
    S_CMP   = 5'b01000,
    S_HIT   = 5'b10000
  } state_e;

endpackage

/* rtl/core/greedy_shift_reduce_recognizer.sv */
// Channel   Direction  Handshake                Payload
// in        sink       in_valid_i/in_ready_o    mode, rule_slot, position, symbol, rhs_length
// out       source     out_valid_o/out_ready_i  action, rule_used, depth, top_symbol, last
// cfg       sink       cfg_valid_i/cfg_ready_o  cfg_data_i (rule_count)
//
// Table writes and end items are taken in S_IDLE. A shift starts a rule search: for each rule tried,
// the right-side symbols are compared one by one (stack memory and rule memory are each read once
// per compare); each reduction restarts the search at rule 0, and the item closes at the end of the
// rule list (or at the reduction limit) with a last beat.
// Reset clears the stack depth, the rule lengths and rule_count (to 1); no clearing pass.
// A full output register stalls the sequencer; the input waits until the item is done.
module greedy_shift_reduce_recognizer
  import gsrr_pkg::*;
#(
  parameter int MAX_RULES      = 16,
  parameter int MAX_RIGHT      = 8,
  parameter int STACK_DEPTH    = 64,
  parameter int MAX_REDUCTIONS = 62
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] rule_slot_i,
  input  logic [3:0] position_i,
  input  logic [7:0] symbol_i,
  input  logic [3:0] rhs_length_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] action_o,
  output logic [3:0] rule_used_o,
  output logic [6:0] depth_o,
  output logic [7:0] top_symbol_o,
  output logic       last_o
);

  localparam int RIDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int RCNT_W = $clog2(MAX_RULES + 1);
  localparam int LW     = $clog2(MAX_RIGHT + 1);
  localparam int RA_W   = (MAX_RULES * MAX_RIGHT > 1) ? $clog2(MAX_RULES * MAX_RIGHT) : 1;
  localparam int SW     = $clog2(STACK_DEPTH);
  localparam int DW     = $clog2(STACK_DEPTH + 1);
  localparam int CW     = $clog2(MAX_REDUCTIONS + 1);

  state_e state_q, state_d;
  logic [4:0]         rule_count_q;
  logic [LW-1:0]      rule_len_q [MAX_RULES];
  logic [7:0]         rule_left_q [MAX_RULES];
  logic [DW-1:0]      depth_q, depth_d;
  logic [7:0]         top_q, top_d;
  logic [7:0]         bottom_q, bottom_d;
  logic [RCNT_W-1:0]  r_q, r_d;
  logic [LW-1:0]      j_q, j_d;
  logic [LW-1:0]      len_q, len_d;
  logic [CW-1:0]      done_q, done_d;
  res_t               pend_q, pend_d;
  logic               flush_q, flush_d;
  logic               out_valid_q;
  res_t               out_q;
  logic               out_last_q;

  // memories
  logic [7:0]      stack_mem [STACK_DEPTH];
  logic [7:0]      right_mem [MAX_RULES * MAX_RIGHT];
  logic [7:0]      stack_rd_q, right_rd_q;
  logic            stack_we;
  logic [SW-1:0]   stack_wa, stack_ra;
  logic [7:0]      stack_wd;
  logic            right_we;
  logic [RA_W-1:0] right_wa, right_ra;

  logic            in_acc, can_emit, emit, emit_last;
  res_t            emit_res;
  logic [RIDX_W-1:0] ridx;
  logic [LW-1:0]   cur_len;
  int              limit;
  logic [DW-1:0]   red_base;

  assign cfg_ready_o = 1'b1;
  assign can_emit    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && !flush_q && can_emit;
  assign in_acc      = in_valid_i && in_ready_o;
  assign ridx        = r_q[RIDX_W-1:0];
  assign cur_len     = rule_len_q[ridx];
  assign limit       = (int'(rule_count_q) > MAX_RULES) ? MAX_RULES : int'(rule_count_q);
  assign red_base    = depth_q - DW'(len_q);

  // memory addresses
  assign stack_ra = SW'(depth_q - DW'(len_q) + DW'(j_q));
  assign right_ra = RA_W'(int'(ridx) * MAX_RIGHT + int'(j_q));
  assign right_we = in_acc && (mode_i == MODE_SYM) && (int'(rule_slot_i) < MAX_RULES)
                    && (position_i != 4'd0) && (int'(position_i) <= MAX_RIGHT);
  assign right_wa = RA_W'(int'(rule_slot_i) * MAX_RIGHT + int'(position_i) - 1);

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_rd_q <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk_i) begin
    if (right_we) right_mem[right_wa] <= symbol_i;
    right_rd_q <= right_mem[right_ra];
  end

  // left symbols, payload only
  always_ff @(posedge clk_i) begin
    if (in_acc && (mode_i == MODE_SYM) && (int'(rule_slot_i) < MAX_RULES)
        && (position_i == 4'd0)) begin
      rule_left_q[RIDX_W'(rule_slot_i)] <= symbol_i;
    end
  end

  // rule lengths and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rule_count_q <= 5'd1;
      for (int i = 0; i < MAX_RULES; i++) rule_len_q[i] <= '0;
    end else begin
      if (cfg_valid_i) rule_count_q <= cfg_data_i;
      if (in_acc && (mode_i == MODE_LEN) && (int'(rule_slot_i) < MAX_RULES)) begin
        rule_len_q[RIDX_W'(rule_slot_i)] <= (int'(rhs_length_i) > MAX_RIGHT) ?
                                            LW'(MAX_RIGHT) : LW'(rhs_length_i);
      end
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    depth_d   = depth_q;
    top_d     = top_q;
    bottom_d  = bottom_q;
    r_d       = r_q;
    j_d       = j_q;
    len_d     = len_q;
    done_d    = done_q;
    pend_d    = pend_q;
    flush_d   = flush_q;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_res  = pend_q;
    stack_we  = 1'b0;
    stack_wa  = SW'(depth_q);
    stack_wd  = symbol_i;

    unique case (state_q)
      S_IDLE: begin
        if (flush_q) begin
          if (can_emit) begin
            emit      = 1'b1;
            emit_last = 1'b1;
            flush_d   = 1'b0;
          end
        end else if (in_acc) begin
          if (mode_i == MODE_END) begin
            emit            = 1'b1;
            emit_last       = 1'b1;
            emit_res.action = ((depth_q == DW'(1)) && (bottom_q == rule_left_q[0])) ?
                              ACT_ACCEPT : ACT_REJECT;
            emit_res.rule   = '0;
            emit_res.depth  = '0;
            emit_res.top    = '0;
            depth_d         = '0;
          end else if (mode_i == MODE_SHIFT) begin
            if (int'(depth_q) >= STACK_DEPTH) begin
              emit            = 1'b1;
              emit_last       = 1'b1;
              emit_res.action = ACT_OVFL;
              emit_res.rule   = '0;
              emit_res.depth  = 7'(depth_q);
              emit_res.top    = (depth_q != '0) ? top_q : 8'd0;
            end else begin
              stack_we      = 1'b1;
              depth_d       = depth_q + DW'(1);
              top_d         = symbol_i;
              if (depth_q == '0) bottom_d = symbol_i;
              pend_d.action = ACT_SHIFT;
              pend_d.rule   = '0;
              pend_d.depth  = 7'(depth_q + DW'(1));
              pend_d.top    = symbol_i;
              r_d           = '0;
              done_d        = '0;
              state_d       = S_RULE;
            end
          end
        end
      end
      S_RULE: begin
        if (int'(r_q) >= limit) begin
          flush_d = 1'b1;
          state_d = S_IDLE;
        end else if ((cur_len == '0) || (int'(cur_len) > int'(depth_q))) begin
          r_d = r_q + RCNT_W'(1);
        end else begin
          len_d   = cur_len;
          j_d     = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_CMP;
      S_CMP: begin
        if (stack_rd_q != right_rd_q) begin
          r_d     = r_q + RCNT_W'(1);
          state_d = S_RULE;
        end else if (j_q + LW'(1) == len_q) begin
          state_d = S_HIT;
        end else begin
          j_d     = j_q + LW'(1);
          state_d = S_RD;
        end
      end
      S_HIT: begin
        if (can_emit) begin
          emit = 1'b1;
          if (int'(done_q) >= MAX_REDUCTIONS) begin
            pend_d.action = ACT_LIMIT;
            pend_d.rule   = '0;
            flush_d       = 1'b1;
            state_d       = S_IDLE;
          end else begin
            // replace matched entries by the left symbol
            stack_we      = 1'b1;
            stack_wa      = SW'(red_base);
            stack_wd      = rule_left_q[ridx];
            depth_d       = red_base + DW'(1);
            top_d         = rule_left_q[ridx];
            if (red_base == '0) bottom_d = rule_left_q[ridx];
            pend_d.action = ACT_REDUCE;
            pend_d.rule   = 4'(ridx);
            pend_d.depth  = 7'(red_base + DW'(1));
            pend_d.top    = rule_left_q[ridx];
            done_d        = done_q + CW'(1);
            r_d           = '0;
            state_d       = S_RULE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      flush_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      flush_q <= flush_d;
      if (emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    bottom_q <= bottom_d;
    r_q      <= r_d;
    j_q      <= j_d;
    len_q    <= len_d;
    done_q   <= done_d;
    pend_q   <= pend_d;
    if (emit) begin
      out_q      <= emit_res;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_q.action;
  assign rule_used_o  = out_q.rule;
  assign depth_o      = out_q.depth;
  assign top_symbol_o = out_q.top;
  assign last_o       = out_last_q;

endmodule

/* test/greedy_shift_reduce_recognizer_test.sv */
`timescale 1ns / 1ps

module greedy_shift_reduce_recognizer_test;
  import gsrr_pkg::*;

  typedef struct {
    logic [1:0] mode;
    logic [3:0] slot;
    logic [3:0] pos;
    logic [7:0] sym;
    logic [3:0] len;
  } token_t;

  typedef struct {
    logic [2:0] action;
    logic [3:0] rule;
    logic [6:0] depth;
    logic [7:0] top;
    logic       last;
  } parse_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] mode = '0;
  logic [3:0] rule_slot = '0;
  logic [3:0] position = '0;
  logic [7:0] symbol = '0;
  logic [3:0] rhs_length = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] action;
  logic [3:0] rule_used;
  logic [6:0] depth;
  logic [7:0] top_symbol;
  logic       last;

  // shadow grammar and stack
  logic [7:0] gram_left [16];
  logic [7:0] gram_right [16][8];
  logic [3:0] gram_len [16];
  logic [7:0] sym_stack [64];
  int         stack_top;
  logic [4:0] rule_count_m;

  token_t     token_q [$];
  logic [4:0] rule_count_q [$];
  parse_res_t parse_res_q [$];
  int         send_idle_pct;
  int         stall_pct;
  int         errors;

  greedy_shift_reduce_recognizer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .mode_i       (mode),
    .rule_slot_i  (rule_slot),
    .position_i   (position),
    .symbol_i     (symbol),
    .rhs_length_i (rhs_length),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .action_o     (action),
    .rule_used_o  (rule_used),
    .depth_o      (depth),
    .top_symbol_o (top_symbol),
    .last_o       (last)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // record one expected result from the current stack
  task automatic push_result(logic [2:0] act, logic [3:0] rule);
    parse_res_t r;
    r.action = act;
    r.rule   = rule;
    r.depth  = stack_top[6:0];
    r.top    = stack_top > 0 ? sym_stack[stack_top - 1] : 8'd0;
    r.last   = 1'b0;
    parse_res_q.push_back(r);
  endtask

  // lowest-numbered rule whose right side matches the stack top
  function automatic int match_rule();
    int lim;
    int n;
    bit ok;
    lim = int'(rule_count_m) < 16 ? int'(rule_count_m) : 16;
    for (int i = 0; i < lim; i++) begin
      n = int'(gram_len[i]);
      if (n == 0 || n > stack_top) continue;
      ok = 1'b1;
      for (int j = 0; j < n; j++)
        if (sym_stack[stack_top - n + j] != gram_right[i][j]) ok = 1'b0;
      if (ok) return i;
    end
    return -1;
  endfunction

  task automatic parse_token(token_t t);
    int r;
    int done;
    bit acc;
    case (t.mode)
      MODE_SYM: begin
        if (t.pos == 0) gram_left[t.slot] = t.sym;
        else if (t.pos <= 8) gram_right[t.slot][t.pos - 1] = t.sym;
      end
      MODE_LEN: gram_len[t.slot] = t.len > 8 ? 4'd8 : t.len;
      MODE_END: begin
        acc = stack_top == 1 && sym_stack[0] == gram_left[0];
        stack_top = 0;
        push_result(acc ? ACT_ACCEPT : ACT_REJECT, 4'd0);
        parse_res_q[$].last = 1'b1;
      end
      default: begin
        if (stack_top >= 64) begin
          push_result(ACT_OVFL, 4'd0);
        end else begin
          sym_stack[stack_top++] = t.sym;
          push_result(ACT_SHIFT, 4'd0);
          done = 0;
          forever begin
            r = match_rule();
            if (r < 0) break;
            if (done >= 62) begin
              push_result(ACT_LIMIT, 4'd0);
              break;
            end
            stack_top -= int'(gram_len[r]);
            sym_stack[stack_top++] = gram_left[r];
            push_result(ACT_REDUCE, r[3:0]);
            done++;
          end
        end
        parse_res_q[$].last = 1'b1;
      end
    endcase
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    token_t t;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        t.mode = mode; t.slot = rule_slot; t.pos = position;
        t.sym = symbol; t.len = rhs_length;
        parse_token(t);
      end
      if (!in_valid || in_ready) begin
        if (token_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          t = token_q.pop_front();
          mode <= t.mode; rule_slot <= t.slot; position <= t.pos;
          symbol <= t.sym; rhs_length <= t.len;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // config driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_ready) begin
        rule_count_m = cfg_data;
        cfg_valid <= 1'b0;
      end
    end else if (rule_count_q.size() > 0) begin
      cfg_data  <= rule_count_q.pop_front();
      cfg_valid <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    parse_res_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (parse_res_q.size() == 0) begin
          $error("unexpected result beat: action %0d", action);
          errors++;
        end else begin
          e = parse_res_q.pop_front();
          if (action !== e.action) begin
            $error("action exp %0d got %0d", e.action, action); errors++;
          end
          if (rule_used !== e.rule) begin
            $error("rule_used exp %0d got %0d", e.rule, rule_used); errors++;
          end
          if (depth !== e.depth) begin
            $error("depth exp %0d got %0d", e.depth, depth); errors++;
          end
          if (top_symbol !== e.top) begin
            $error("top_symbol exp %0d got %0d", e.top, top_symbol); errors++;
          end
          if (last !== e.last) begin
            $error("last exp %0d got %0d", e.last, last); errors++;
          end
        end
      end
      out_ready <= $urandom_range(99) >= stall_pct;
    end
  end

  task automatic add(logic [1:0] m, int s, int p, int y, int l);
    token_t t;
    t.mode = m; t.slot = s[3:0]; t.pos = p[3:0]; t.sym = y[7:0]; t.len = l[3:0];
    token_q.push_back(t);
  endtask

  // wait for the block to drain, then for the longest search to settle
  task automatic wait_idle();
    while (token_q.size() > 0 || in_valid || parse_res_q.size() > 0 || cfg_valid ||
           rule_count_q.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_rule_count(logic [4:0] v);
    wait_idle();
    rule_count_q.push_back(v);
    wait_idle();
  endtask

  // one random phase: small grammars and sentences, with some noise
  task automatic random_phase(int items);
    int n;
    int nr;
    int k;
    n = 0;
    while (n < items) begin
      nr = $urandom_range(1, 5);
      for (int r = 0; r < nr; r++) begin
        add(MODE_SYM, r, 0, $urandom_range(1, 5), 0);
        k = $urandom_range(1, 3);
        for (int j = 1; j <= k; j++) add(MODE_SYM, r, j, $urandom_range(1, 5), 0);
        add(MODE_LEN, r, 0, 0, k);
        n += k + 2;
      end
      for (int r = nr; r < 16; r++)
        if ($urandom_range(3) == 0) begin
          add(MODE_LEN, r, 0, 0, 0);
          n++;
        end
      repeat ($urandom_range(1, 4)) begin
        repeat ($urandom_range(1, 7)) begin
          case ($urandom_range(9))
            0: add(MODE_SHIFT, 0, 0, $urandom_range(255), 0);
            1: add(MODE_SYM, $urandom_range(15), $urandom_range(15), $urandom, 0);
            2: add(MODE_LEN, $urandom_range(15), 0, 0, $urandom_range(15));
            default: add(MODE_SHIFT, $urandom, $urandom, $urandom_range(1, 5), $urandom);
          endcase
          n++;
        end
        if ($urandom_range(9) != 0) begin
          add(MODE_END, $urandom, $urandom, $urandom, $urandom);
          n++;
        end
      end
    end
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rule_count_m = 5'd1;
    stack_top = 0;
    for (int i = 0; i < 16; i++) gram_len[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // write every rule symbol so that no unwritten entry is ever read
    for (int r = 0; r < 16; r++)
      for (int p = 0; p <= 8; p++) add(MODE_SYM, r, p, $urandom, 0);
    set_rule_count(5'd16);

    // rule 0: 1 -> 2 3, rule 1: 2 -> 4, rule 2: 5 -> 5 (self loop), rule 3: long length
    add(MODE_SYM, 0, 0, 1, 0); add(MODE_SYM, 0, 1, 2, 0); add(MODE_SYM, 0, 2, 3, 0);
    add(MODE_LEN, 0, 0, 0, 2);
    add(MODE_SYM, 1, 0, 2, 0); add(MODE_SYM, 1, 1, 4, 0); add(MODE_LEN, 1, 0, 0, 1);
    add(MODE_SYM, 2, 0, 5, 0); add(MODE_SYM, 2, 1, 5, 0); add(MODE_LEN, 2, 0, 0, 1);
    add(MODE_SYM, 3, 15, 8'hFF, 0);     // position out of range, ignored
    add(MODE_LEN, 3, 0, 0, 15);         // clamped to full length
    add(MODE_SHIFT, 0, 0, 4, 0);
    add(MODE_SHIFT, 0, 0, 3, 0);
    add(MODE_END, 0, 0, 0, 0);          // accept
    add(MODE_END, 0, 0, 0, 0);          // reject on empty stack
    add(MODE_SHIFT, 0, 0, 5, 0);        // runs into the reduction limit
    add(MODE_SHIFT, 0, 0, 8'hFF, 0);
    add(MODE_SHIFT, 0, 0, 8'h00, 0);
    add(MODE_END, 15, 15, 8'hFF, 15);
    // fill the stack, then overflow
    repeat (65) add(MODE_SHIFT, 0, 0, 8'hC8, 0);
    add(MODE_END, 0, 0, 0, 0);

    // no rule tried at all
    set_rule_count(5'd0);
    add(MODE_SHIFT, 0, 0, 4, 0); add(MODE_SHIFT, 0, 0, 3, 0); add(MODE_END, 0, 0, 0, 0);
    set_rule_count(5'd31);
    add(MODE_SHIFT, 0, 0, 4, 0); add(MODE_SHIFT, 0, 0, 3, 0); add(MODE_END, 0, 0, 0, 0);
    set_rule_count(5'd1);
    add(MODE_SHIFT, 0, 0, 2, 0); add(MODE_SHIFT, 0, 0, 3, 0); add(MODE_END, 0, 0, 0, 0);

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      set_rule_count(ph == 0 ? 5'd31 : (ph == 1 ? 5'd16 : 5'($urandom_range(1, 31))));
      random_phase(40);
    end

    wait_idle();
    repeat (100) @(posedge clk_i);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gsrr_pkg.sv
rtl/core/greedy_shift_reduce_recognizer.sv
test/greedy_shift_reduce_recognizer_test.sv
